>>> sv/kt2_pkg.sv
// ============================================================================
// kt2_pkg
// Shared types and constants of the 2-D constant-velocity Kalman tracker.
// ============================================================================
package kt2_pkg;

    // Default number format (Q16.16 in 32 bits)
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Port field widths
    localparam int IN_W      = 32;
    localparam int REG_W     = 31;
    localparam int CFG_IDX_W = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COV   = 8'd3;

    // Register reset values
    localparam logic [REG_W-1:0] RST_STEP_TIME     = 31'd1966080;  // 30.0
    localparam logic [REG_W-1:0] RST_PROCESS_NOISE = 31'd655;      // 0.01
    localparam logic [REG_W-1:0] RST_MEASURE_NOISE = 31'd3276800;  // 50.0
    localparam logic [REG_W-1:0] RST_INITIAL_COV   = 31'd6553600;  // 100.0

    // Processing phases of one measurement
    typedef enum logic [3:0] {
        PH_PV,   // predicted state
        PH_T1,   // F * P
        PH_T2,   // (F * P) * F'
        PH_Q,    // process noise on diagonal
        PH_S,    // innovation covariance diagonal
        PH_DET,  // determinant
        PH_DIV,  // inverse entries
        PH_E,    // innovation
        PH_G,    // gain
        PH_EST,  // state update
        PH_COV   // covariance update
    } t_phase;

    // Commands from controller to datapath
    typedef struct packed {
        t_phase     phase;
        logic [1:0] idx_i;
        logic [1:0] idx_j;
        logic [1:0] idx_k;
        logic       load;
        logic       mul_go;
        logic       acc_en;
        logic       acc_last;
        logic       add_en;
        logic       div_go;
        logic       div_wb;
        logic       sing;
        logic       out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic det_pos;
        logic out_busy;
    } t_status;

endpackage

>>> sv/kt2_mul.sv
// ============================================================================
// kt2_mul
// Multi-cycle fixed-point multiplier: four half-width partial products,
// round to nearest (ties away from zero), saturate.
// ============================================================================
module kt2_mul #(
    parameter int DATA_WIDTH = kt2_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kt2_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_res
);

    localparam int DW = DATA_WIDTH;
    localparam int H  = (DW + 1) / 2;
    localparam int PW = 2 * DW;

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [PW:0] MAXW = {{(DW+2){1'b0}}, {(DW-1){1'b1}}};
    localparam logic [PW:0] RND  = (PW+1)'(1) << (FRAC_BITS - 1);

    logic              r_busy;
    logic [2:0]        r_cnt;
    logic [2*H-1:0]    r_ma;
    logic [2*H-1:0]    r_mb;
    logic              r_neg;
    logic [2*H-1:0]    r_pp;
    logic [1:0]        r_sh;
    logic              r_pp_vld;
    logic [PW-1:0]     r_p;
    logic              r_done;
    logic signed [DW-1:0] r_res;

    logic [DW-1:0]     mag_a;
    logic [DW-1:0]     mag_b;
    logic [H-1:0]      half_a;
    logic [H-1:0]      half_b;
    logic [PW-1:0]     pp_ext;
    logic [PW-1:0]     pp_shift;
    logic [PW:0]       rnd_sum;
    logic [PW:0]       rnd_m;

    // operand magnitudes
    assign mag_a = i_a[DW-1] ? DW'(-i_a) : DW'(i_a);
    assign mag_b = i_b[DW-1] ? DW'(-i_b) : DW'(i_b);

    // partial product halves
    assign half_a = r_cnt[1] ? r_ma[2*H-1:H] : r_ma[H-1:0];
    assign half_b = r_cnt[0] ? r_mb[2*H-1:H] : r_mb[H-1:0];

    // align the registered partial product
    assign pp_ext = PW'(r_pp);
    always_comb begin
        unique case (r_sh)
            2'd0:    pp_shift = pp_ext;
            2'd1:    pp_shift = pp_ext << H;
            default: pp_shift = pp_ext << (2 * H);
        endcase
    end

    // rounding of the full product
    assign rnd_sum = {1'b0, r_p} + RND;
    assign rnd_m   = rnd_sum >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_ma     <= (2*H)'(mag_a);
            r_mb     <= (2*H)'(mag_b);
            r_neg    <= i_a[DW-1] ^ i_b[DW-1];
            r_cnt    <= 3'd0;
            r_p      <= '0;
            r_pp_vld <= 1'b0;
            r_busy   <= 1'b1;
        end else if (r_busy) begin
            if (r_pp_vld) begin
                r_p <= r_p + pp_shift;
            end
            if (r_cnt <= 3'd3) begin
                r_pp     <= (2*H)'(half_a * half_b);
                r_sh     <= 2'(r_cnt[1] + r_cnt[0]);
                r_pp_vld <= 1'b1;
                r_cnt    <= r_cnt + 3'd1;
            end else if (r_cnt == 3'd4) begin
                r_pp_vld <= 1'b0;
                r_cnt    <= r_cnt + 3'd1;
            end else begin
                if (rnd_m > MAXW) begin
                    r_res <= r_neg ? VMIN : VMAX;
                end else begin
                    r_res <= r_neg ? -$signed(rnd_m[DW-1:0]) : $signed(rnd_m[DW-1:0]);
                end
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end
        end
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
            r_pp_vld <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> sv/kt2_div.sv
// ============================================================================
// kt2_div
// Bit-serial restoring divider: (n << FRAC_BITS) / d for d > 0,
// truncated toward zero and saturated. One quotient bit per cycle.
// ============================================================================
module kt2_div #(
    parameter int DATA_WIDTH = kt2_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kt2_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_num,
    input  logic signed [DATA_WIDTH-1:0] i_den,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_res
);

    localparam int DW = DATA_WIDTH;
    localparam int NW = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [NW-1:0] MAXQ = {{(NW-DW+1){1'b0}}, {(DW-1){1'b1}}};

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [NW-1:0]     r_num;
    logic [DW:0]       r_rem;
    logic [DW-1:0]     r_den;
    logic [NW-1:0]     r_q;
    logic              r_neg;
    logic              r_done;
    logic signed [DW-1:0] r_res;

    logic [DW-1:0]     mag_n;
    logic [DW:0]       rem_sh;
    logic              q_bit;

    assign mag_n = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);

    // one trial subtraction
    assign rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (i_start) begin
            r_num  <= {mag_n, {FRAC_BITS{1'b0}}};
            r_den  <= i_den;
            r_neg  <= i_num[DW-1];
            r_rem  <= '0;
            r_q    <= '0;
            r_cnt  <= CW'(NW);
            r_busy <= 1'b1;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem <= q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
                r_q   <= {r_q[NW-2:0], q_bit};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - CW'(1);
            end else begin
                if (r_q > MAXQ) begin
                    r_res <= r_neg ? VMIN : VMAX;
                end else begin
                    r_res <= r_neg ? -$signed(r_q[DW-1:0]) : $signed(r_q[DW-1:0]);
                end
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> sv/kt2_datapath.sv
// ============================================================================
// kt2_datapath
// Tracker datapath: configuration registers, state and covariance storage,
// operand selection, shared multiplier and divider, saturating accumulator,
// output register.
// ============================================================================
module kt2_datapath #(
    parameter int DATA_WIDTH = kt2_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kt2_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_valid,
    input  logic [kt2_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kt2_pkg::REG_W-1:0]       i_cfg_data,
    // measurement
    input  logic [kt2_pkg::IN_W-1:0]        i_meas_x,
    input  logic [kt2_pkg::IN_W-1:0]        i_meas_y,
    // control
    input  kt2_pkg::t_cmd                   i_cmd,
    output kt2_pkg::t_status                o_st,
    // result
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [kt2_pkg::IN_W-1:0]        o_est_x,
    output logic [kt2_pkg::IN_W-1:0]        o_est_y,
    output logic                            o_flag
);

    localparam int DW = DATA_WIDTH;

    localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [64:0]          MAX65  = (65'd1 << (DW - 1)) - 65'd1;
    localparam logic signed [64:0]   MAX65S = $signed(MAX65);
    localparam logic signed [64:0]   MIN65S = -MAX65S - 65'sd1;
    localparam logic [64:0]          ONE_RAW = 65'd1 << FRAC_BITS;
    localparam logic signed [DW-1:0] ONE = (ONE_RAW > MAX65) ? VMAX : ONE_RAW[DW-1:0];

    // ---------------------------------------------------------------- helpers
    function automatic logic signed [DW-1:0] f_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] f_sub(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) return s[DW] ? VMIN : VMAX;
        return s[DW-1:0];
    endfunction

    // register value limited to the number range
    function automatic logic signed [DW-1:0] f_reg(input logic [kt2_pkg::REG_W-1:0] r);
        logic [64:0] w;
        w = 65'(r);
        return (w > MAX65) ? VMAX : w[DW-1:0];
    endfunction

    // 32-bit input sign-extended and limited to the number range
    function automatic logic signed [DW-1:0] f_in(input logic [kt2_pkg::IN_W-1:0] x);
        logic signed [64:0] s;
        s = {{33{x[31]}}, x};
        if (s > MAX65S) return VMAX;
        if (s < MIN65S) return VMIN;
        return s[DW-1:0];
    endfunction

    // value limited to the 32-bit output range
    function automatic logic [kt2_pkg::IN_W-1:0] f_out(input logic signed [DW-1:0] v);
        logic signed [64:0] s;
        s = {{(65-DW){v[DW-1]}}, v};
        if (s > 65'sd2147483647) return 32'h7fff_ffff;
        if (s < -65'sd2147483648) return 32'h8000_0000;
        return s[31:0];
    endfunction

    // transition matrix entry
    function automatic logic signed [DW-1:0] f_trans(input logic [1:0] row,
                                                     input logic [1:0] col,
                                                     input logic signed [DW-1:0] dt);
        if (row == col) return ONE;
        if ((row == 2'd0 && col == 2'd1) || (row == 2'd2 && col == 2'd3)) return dt;
        return '0;
    endfunction

    // ------------------------------------------------------------- registers
    logic [kt2_pkg::REG_W-1:0] r_step, r_qn, r_rn, r_ic;
    logic                      r_first;

    logic signed [DW-1:0] r_est [4];
    logic signed [DW-1:0] r_cov [16];
    logic signed [DW-1:0] r_pv  [4];
    logic signed [DW-1:0] r_tmp [16];
    logic signed [DW-1:0] r_pc  [16];
    logic signed [DW-1:0] r_inv [4];
    logic signed [DW-1:0] r_g   [8];
    logic signed [DW-1:0] r_e   [2];
    logic signed [DW-1:0] r_s00, r_s11, r_det, r_acc, r_zx, r_zy;
    logic                 r_sing;

    logic                        r_out_valid;
    logic [kt2_pkg::IN_W-1:0]    r_out_x, r_out_y;
    logic                        r_out_flag;

    // --------------------------------------------------------- control decode
    logic [1:0] ci, cj, ck;
    logic signed [DW-1:0] tstep, qn, rn, ic;
    logic signed [DW-1:0] op_a, op_b, num;
    logic signed [DW-1:0] acc_base, acc_new;
    logic signed [DW-1:0] mul_res, div_res;
    logic                 mul_done, div_done;

    assign ci = i_cmd.idx_i;
    assign cj = i_cmd.idx_j;
    assign ck = i_cmd.idx_k;

    assign tstep = f_reg(r_step);
    assign qn    = f_reg(r_qn);
    assign rn    = f_reg(r_rn);
    assign ic    = f_reg(r_ic);

    // multiplier operand selection per phase
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.phase)
            kt2_pkg::PH_PV: begin
                op_a = f_trans(ci, ck, tstep);
                op_b = r_est[ck];
            end
            kt2_pkg::PH_T1: begin
                op_a = f_trans(ci, ck, tstep);
                op_b = r_cov[{ck, cj}];
            end
            kt2_pkg::PH_T2: begin
                op_a = r_tmp[{ci, ck}];
                op_b = f_trans(cj, ck, tstep);
            end
            kt2_pkg::PH_DET: begin
                op_a = (ck == 2'd0) ? r_s00 : r_pc[2];
                op_b = (ck == 2'd0) ? r_s11 : r_pc[8];
            end
            kt2_pkg::PH_G: begin
                op_a = r_pc[{ci, ck[0], 1'b0}];
                op_b = r_inv[{ck[0], cj[0]}];
            end
            kt2_pkg::PH_EST: begin
                op_a = r_g[{ck[0], ci}];
                op_b = r_e[ck[0]];
            end
            kt2_pkg::PH_COV: begin
                op_a = r_g[{ck[0], ci}];
                op_b = r_pc[{ck[0], 1'b0, cj}];
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // divider numerator: entries of the adjugate
    always_comb begin
        unique case (ci)
            2'd0:    num = r_s11;
            2'd1:    num = f_sub('0, r_pc[2]);
            2'd2:    num = f_sub('0, r_pc[8]);
            default: num = r_s00;
        endcase
    end

    // saturating accumulator
    assign acc_base = (ck != 2'd0) ? r_acc :
                      ((i_cmd.phase == kt2_pkg::PH_EST) ? r_pv[ci] : '0);
    assign acc_new  = (i_cmd.phase == kt2_pkg::PH_DET && ck == 2'd1) ?
                      f_sub(acc_base, mul_res) : f_add(acc_base, mul_res);

    kt2_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_go),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    kt2_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (num),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    // ---------------------------------------------------------- config regs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= kt2_pkg::RST_STEP_TIME;
            r_qn   <= kt2_pkg::RST_PROCESS_NOISE;
            r_rn   <= kt2_pkg::RST_MEASURE_NOISE;
            r_ic   <= kt2_pkg::RST_INITIAL_COV;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == kt2_pkg::CFG_STEP_TIME)     r_step <= i_cfg_data;
            if (i_cfg_index == kt2_pkg::CFG_PROCESS_NOISE) r_qn   <= i_cfg_data;
            if (i_cfg_index == kt2_pkg::CFG_MEASURE_NOISE) r_rn   <= i_cfg_data;
            if (i_cfg_index == kt2_pkg::CFG_INITIAL_COV)   r_ic   <= i_cfg_data;
        end
    end

    // ------------------------------------------------------- filter storage
    always_ff @(posedge i_clk) begin
        // measurement capture and first-item start
        if (i_cmd.load) begin
            r_zx   <= f_in(i_meas_x);
            r_zy   <= f_in(i_meas_y);
            r_sing <= 1'b0;
            if (r_first) begin
                r_first <= 1'b0;
                for (int n = 0; n < 4; n++) r_est[n] <= '0;
                for (int n = 0; n < 16; n++) r_cov[n] <= (n % 5 == 0) ? ic : '0;
            end
        end

        // product accumulation and write-back
        if (i_cmd.acc_en) begin
            r_acc <= acc_new;
            if (i_cmd.acc_last) begin
                unique case (i_cmd.phase)
                    kt2_pkg::PH_PV:  r_pv[ci]         <= acc_new;
                    kt2_pkg::PH_T1:  r_tmp[{ci, cj}]  <= acc_new;
                    kt2_pkg::PH_T2:  r_pc[{ci, cj}]   <= acc_new;
                    kt2_pkg::PH_DET: r_det            <= acc_new;
                    kt2_pkg::PH_G:   r_g[{cj[0], ci}] <= acc_new;
                    kt2_pkg::PH_EST: r_est[ci]        <= acc_new;
                    kt2_pkg::PH_COV: r_cov[{ci, cj}]  <= f_sub(r_pc[{ci, cj}], acc_new);
                    default: ;
                endcase
            end
        end

        // additions outside the multiplier
        if (i_cmd.add_en) begin
            unique case (i_cmd.phase)
                kt2_pkg::PH_Q: begin
                    r_pc[0]  <= f_add(r_pc[0], qn);
                    r_pc[5]  <= f_add(r_pc[5], qn);
                    r_pc[10] <= f_add(r_pc[10], qn);
                    r_pc[15] <= f_add(r_pc[15], qn);
                end
                kt2_pkg::PH_S: begin
                    r_s00 <= f_add(r_pc[0], rn);
                    r_s11 <= f_add(r_pc[10], rn);
                end
                kt2_pkg::PH_E: begin
                    r_e[0] <= f_sub(r_zx, r_pv[0]);
                    r_e[1] <= f_sub(r_zy, r_pv[2]);
                end
                default: ;
            endcase
        end

        // inverse entries
        if (i_cmd.div_wb) begin
            r_inv[ci] <= div_res;
        end

        // singular innovation: keep the prediction
        if (i_cmd.sing) begin
            r_sing <= 1'b1;
            for (int n = 0; n < 4; n++) r_est[n] <= r_pv[n];
            for (int n = 0; n < 16; n++) r_cov[n] <= r_pc[n];
        end

        if (!i_rst_n) begin
            r_first <= 1'b1;
        end
    end

    // ------------------------------------------------------ output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_x    <= f_out(r_est[0]);
            r_out_y    <= f_out(r_est[2]);
            r_out_flag <= r_sing;
        end
    end

    // status
    assign o_st.mul_done = mul_done;
    assign o_st.div_done = div_done;
    assign o_st.det_pos  = !r_det[DW-1] && (r_det != '0);
    assign o_st.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_est_x     = r_out_x;
    assign o_est_y     = r_out_y;
    assign o_flag      = r_out_flag;

endmodule

>>> sv/kt2_ctrl.sv
// ============================================================================
// kt2_ctrl
// Tracker sequencer: walks the phases of one measurement and the
// row/column/term counters of each, issuing datapath commands.
// ============================================================================
module kt2_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output kt2_pkg::t_cmd    o_cmd,
    input  kt2_pkg::t_status i_st
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MGO,
        S_MWAIT,
        S_ADD,
        S_CHK,
        S_DGO,
        S_DWAIT,
        S_SING,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    kt2_pkg::t_phase   r_phase, n_phase;
    logic [1:0]        r_i, r_j, r_k, n_i, n_j, n_k;
    logic [1:0]        imax, jmax, kmax;

    // loop bounds of each phase
    always_comb begin
        unique case (r_phase)
            kt2_pkg::PH_PV:  {imax, jmax, kmax} = {2'd3, 2'd0, 2'd3};
            kt2_pkg::PH_T1:  {imax, jmax, kmax} = {2'd3, 2'd3, 2'd3};
            kt2_pkg::PH_T2:  {imax, jmax, kmax} = {2'd3, 2'd3, 2'd3};
            kt2_pkg::PH_DET: {imax, jmax, kmax} = {2'd0, 2'd0, 2'd1};
            kt2_pkg::PH_G:   {imax, jmax, kmax} = {2'd3, 2'd1, 2'd1};
            kt2_pkg::PH_EST: {imax, jmax, kmax} = {2'd3, 2'd0, 2'd1};
            kt2_pkg::PH_COV: {imax, jmax, kmax} = {2'd3, 2'd3, 2'd1};
            default:         {imax, jmax, kmax} = {2'd3, 2'd0, 2'd0};
        endcase
    end

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MGO;
                    n_phase = kt2_pkg::PH_PV;
                    n_i     = 2'd0;
                    n_j     = 2'd0;
                    n_k     = 2'd0;
                end
            end
            S_MGO: n_state = S_MWAIT;
            S_MWAIT: begin
                if (i_st.mul_done) begin
                    n_state = S_MGO;
                    if (r_k != kmax) begin
                        n_k = r_k + 2'd1;
                    end else if (r_j != jmax) begin
                        n_k = 2'd0;
                        n_j = r_j + 2'd1;
                    end else if (r_i != imax) begin
                        n_k = 2'd0;
                        n_j = 2'd0;
                        n_i = r_i + 2'd1;
                    end else begin
                        n_k = 2'd0;
                        n_j = 2'd0;
                        n_i = 2'd0;
                        unique case (r_phase)
                            kt2_pkg::PH_PV:  n_phase = kt2_pkg::PH_T1;
                            kt2_pkg::PH_T1:  n_phase = kt2_pkg::PH_T2;
                            kt2_pkg::PH_T2: begin
                                n_phase = kt2_pkg::PH_Q;
                                n_state = S_ADD;
                            end
                            kt2_pkg::PH_DET: n_state = S_CHK;
                            kt2_pkg::PH_G:   n_phase = kt2_pkg::PH_EST;
                            kt2_pkg::PH_EST: n_phase = kt2_pkg::PH_COV;
                            default:         n_state = S_OUT;
                        endcase
                    end
                end
            end
            S_ADD: begin
                unique case (r_phase)
                    kt2_pkg::PH_Q: n_phase = kt2_pkg::PH_S;
                    kt2_pkg::PH_S: begin
                        n_phase = kt2_pkg::PH_DET;
                        n_state = S_MGO;
                    end
                    kt2_pkg::PH_E: begin
                        n_phase = kt2_pkg::PH_G;
                        n_state = S_MGO;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_CHK: begin
                if (i_st.det_pos) begin
                    n_phase = kt2_pkg::PH_DIV;
                    n_state = S_DGO;
                end else begin
                    n_state = S_SING;
                end
            end
            S_DGO: n_state = S_DWAIT;
            S_DWAIT: begin
                if (i_st.div_done) begin
                    if (r_i != 2'd3) begin
                        n_i     = r_i + 2'd1;
                        n_state = S_DGO;
                    end else begin
                        n_i     = 2'd0;
                        n_phase = kt2_pkg::PH_E;
                        n_state = S_ADD;
                    end
                end
            end
            S_SING: n_state = S_OUT;
            S_OUT: begin
                if (!i_st.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= kt2_pkg::PH_PV;
            r_i     <= 2'd0;
            r_j     <= 2'd0;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // command decode
    assign o_in_ready = (r_state == S_IDLE);

    assign o_cmd.phase    = r_phase;
    assign o_cmd.idx_i    = r_i;
    assign o_cmd.idx_j    = r_j;
    assign o_cmd.idx_k    = r_k;
    assign o_cmd.load     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.mul_go   = (r_state == S_MGO);
    assign o_cmd.acc_en   = (r_state == S_MWAIT) && i_st.mul_done;
    assign o_cmd.acc_last = (r_k == kmax);
    assign o_cmd.add_en   = (r_state == S_ADD);
    assign o_cmd.div_go   = (r_state == S_DGO);
    assign o_cmd.div_wb   = (r_state == S_DWAIT) && i_st.div_done;
    assign o_cmd.sing     = (r_state == S_SING);
    assign o_cmd.out_load = (r_state == S_OUT) && !i_st.out_busy;

endmodule

>>> sv/kalman_tracker_2d_cv.sv
// ============================================================================
// kalman_tracker_2d_cv
// Two-dimensional constant-velocity Kalman tracker, fixed point.
// ============================================================================
// s_axis carries one position measurement per transfer; m_axis returns one
// transfer per measurement with the filtered x, y and, in tuser, a flag set
// when the innovation determinant was not positive (prediction kept).
// The config channel writes step_time, process_noise, measure_noise and
// initial_cov by index 0..3, ignores other indexes and is always ready;
// the user must write it only while no measurement is in flight, which
// the block itself does not enforce. One shared multiplier (202 products,
// 146 when the update is skipped) and a bit-serial divider (four inverse
// entries) do the arithmetic, in Q16.16 by default.
// s_axis_tready is high only while the block is idle between items, so a
// new item is taken only after the last result is in the output register.
// A stalled receiver holds the block only once the next result is ready.
// Reset restores the register defaults and makes the next item restart
// from a zero estimate with initial_cov on the diagonal.
// ============================================================================
module kalman_tracker_2d_cv #(
    parameter int DATA_WIDTH = kt2_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = kt2_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // measurement stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,   // meas_x [31:0], meas_y [63:32]
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,   // est_x [31:0], est_y [63:32]
    output logic [0:0]                    m_axis_tuser,   // singular_flag [0]
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kt2_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [kt2_pkg::REG_W-1:0]     i_cfg_data
);

    kt2_pkg::t_cmd    cmd;
    kt2_pkg::t_status st;
    logic             cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    kt2_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_st       (st)
    );

    kt2_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_meas_x    (s_axis_tdata[31:0]),
        .i_meas_y    (s_axis_tdata[63:32]),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_est_x     (m_axis_tdata[31:0]),
        .o_est_y     (m_axis_tdata[63:32]),
        .o_flag      (m_axis_tuser[0])
    );

endmodule

>>> sv/kt2_checker.sv
// ============================================================================
// kt2_checker
// Port-level checks of the tracker's stream behavior, bound to the top.
// ============================================================================
module kt2_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // one item at a time: input closes after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready after accepting an item");

    // a new result appears only at the end of processing
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without processing");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind kalman_tracker_2d_cv kt2_checker u_chk (.*);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the 2-D constant-velocity Kalman tracker.
// ============================================================================
// Measurements are streamed in bursts with random gaps, and the result port
// stalls on a changing pattern. A bit-exact fixed-point predictor runs
// alongside: each accepted measurement is pushed through it, and every result
// transfer is compared field by field with the oldest queued estimate.
// The tests cover the first-item load, singular innovation, input extremes,
// several register settings including the range limits, and a long output
// stall that backs up the input. The rest is random and track-like.
// ============================================================================
module tb_top;

    localparam longint          Q_MAX   = 64'sh7FFF_FFFF;
    localparam longint          Q_MIN   = -64'sh8000_0000;
    localparam longint unsigned MAG_LIM = 64'h7FFF_FFFF;
    localparam int              FRAC    = 16;
    localparam longint          Q_ONE   = 64'sd65536;
    localparam logic [kt2_pkg::REG_W-1:0] REG_MAX = {kt2_pkg::REG_W{1'b1}};
    localparam logic [kt2_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_LO = 8'd4;
    localparam logic [kt2_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED_HI = 8'd255;

    typedef longint mat16_t [16];
    typedef longint vec4_t [4];

    typedef struct {
        logic [31:0] est_x;
        logic [31:0] est_y;
        logic        singular;
    } est_t;

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [63:0]                   s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [63:0]                   m_axis_tdata;
    logic [0:0]                    m_axis_tuser;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [kt2_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [kt2_pkg::REG_W-1:0]     i_cfg_data = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    kalman_tracker_2d_cv i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor: registers and state
    // ------------------------------------------------------------------------
    logic [kt2_pkg::REG_W-1:0] dt_reg    = kt2_pkg::RST_STEP_TIME;
    logic [kt2_pkg::REG_W-1:0] qn_reg    = kt2_pkg::RST_PROCESS_NOISE;
    logic [kt2_pkg::REG_W-1:0] rn_reg    = kt2_pkg::RST_MEASURE_NOISE;
    logic [kt2_pkg::REG_W-1:0] pinit_reg = kt2_pkg::RST_INITIAL_COV;
    vec4_t  trk_est;
    mat16_t trk_cov;
    bit     trk_fresh = 1'b1;

    est_t   est_q [$];
    int     n_err = 0;

    function automatic longint q_sat(longint v);
        return v > Q_MAX ? Q_MAX : (v < Q_MIN ? Q_MIN : v);
    endfunction

    function automatic longint q_add(longint a, longint b);
        return q_sat(a + b);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return q_sat(a - b);
    endfunction

    // signed result from a magnitude, saturated
    function automatic longint q_mag(longint unsigned m, bit neg);
        if (m > MAG_LIM)
            return neg ? Q_MIN : Q_MAX;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // product, rounded half away from zero
    function automatic longint q_mul(longint a, longint b);
        longint unsigned ma, mb, m;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        m = (ma * mb + 64'd32768) >> FRAC;
        return q_mag(m, (a < 0) != (b < 0));
    endfunction

    // (n << FRAC) / d for d > 0, truncated
    function automatic longint q_div(longint n, longint d);
        longint unsigned m;
        m = (n < 0) ? -n : n;
        return q_mag((m << FRAC) / longint'(d), n < 0);
    endfunction

    function automatic mat16_t mat_mul(mat16_t a, mat16_t b);
        mat16_t c;
        longint s;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
                s = 0;
                for (int k = 0; k < 4; k++) s = q_add(s, q_mul(a[i*4+k], b[k*4+j]));
                c[i*4+j] = s;
            end
        return c;
    endfunction

    // advance the tracker by one measurement and return the expected result
    function automatic est_t track_step(logic [31:0] mx, logic [31:0] my);
        mat16_t f, ft, pc;
        vec4_t  pv, g0, g1;
        longint zx, zy, dt, s00, s01, s10, s11, det, i00, i01, i10, i11, e0, e1, s, kh;
        est_t   r;
        zx = longint'(signed'(mx));
        zy = longint'(signed'(my));
        dt = longint'(dt_reg);
        if (trk_fresh) begin
            foreach (trk_est[i]) trk_est[i] = 0;
            foreach (trk_cov[i]) trk_cov[i] = (i % 5 == 0) ? longint'(pinit_reg) : 0;
            trk_fresh = 1'b0;
        end
        foreach (f[i]) begin
            f[i] = (i % 5 == 0) ? Q_ONE : 0;
            ft[i] = f[i];
        end
        f[1] = dt;  f[11] = dt;
        ft[4] = dt; ft[14] = dt;

        // prediction
        for (int i = 0; i < 4; i++) begin
            s = 0;
            for (int k = 0; k < 4; k++) s = q_add(s, q_mul(f[i*4+k], trk_est[k]));
            pv[i] = s;
        end
        pc = mat_mul(mat_mul(f, trk_cov), ft);
        for (int i = 0; i < 4; i++) pc[i*5] = q_add(pc[i*5], longint'(qn_reg));

        // innovation covariance and its determinant
        s00 = q_add(pc[0], longint'(rn_reg));
        s01 = pc[2];
        s10 = pc[8];
        s11 = q_add(pc[10], longint'(rn_reg));
        det = q_sub(q_mul(s00, s11), q_mul(s01, s10));

        if (det <= 0) begin
            trk_est = pv;
            trk_cov = pc;
        end else begin
            i00 = q_div(s11, det);
            i01 = q_div(q_sub(0, s01), det);
            i10 = q_div(q_sub(0, s10), det);
            i11 = q_div(s00, det);
            e0 = q_sub(zx, pv[0]);
            e1 = q_sub(zy, pv[2]);
            for (int i = 0; i < 4; i++) begin
                g0[i] = q_add(q_mul(pc[i*4], i00), q_mul(pc[i*4+2], i10));
                g1[i] = q_add(q_mul(pc[i*4], i01), q_mul(pc[i*4+2], i11));
            end
            for (int i = 0; i < 4; i++)
                trk_est[i] = q_add(q_add(pv[i], q_mul(g0[i], e0)), q_mul(g1[i], e1));
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++) begin
                    kh = q_add(q_mul(g0[i], pc[j]), q_mul(g1[i], pc[8+j]));
                    trk_cov[i*4+j] = q_sub(pc[i*4+j], kh);
                end
        end
        r.est_x = trk_est[0][31:0];
        r.est_y = trk_est[2][31:0];
        r.singular = (det <= 0);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall pattern and long hold-off
    // ------------------------------------------------------------------------
    int   hold_len = 0;
    bit   hold_tog = 1'b0;
    bit   hold_seen = 1'b0;
    int   hold_cnt = 0;
    int   stall_mode = 0;
    logic [7:0] stall_pat = 8'b1011_0110;

    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_cnt <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            stall_pat <= {stall_pat[6:0], stall_pat[7]};
            case (stall_mode)
                0: begin
                    m_axis_tready <= 1'b1;
                end
                1: begin
                    m_axis_tready <= ($urandom_range(0, 3) != 0);
                end
                2: begin
                    m_axis_tready <= stall_pat[0];
                end
                default: begin
                    m_axis_tready <= ($urandom_range(0, 7) == 0);
                end
            endcase
        end
    end

    // check every result transfer against the oldest expected estimate
    always @(posedge i_clk) begin
        est_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (est_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result: x=%h y=%h flag=%b",
                             m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0]);
            end else begin
                e = est_q.pop_front();
                if (m_axis_tdata[31:0] !== e.est_x || m_axis_tdata[63:32] !== e.est_y ||
                    m_axis_tuser[0] !== e.singular) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp x=%h y=%h flag=%b  got x=%h y=%h flag=%b",
                                 e.est_x, e.est_y, e.singular, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tuser[0]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Measurement side
    // ------------------------------------------------------------------------
    int  burst_left = 4;
    bit  gaps_on = 1'b1;
    longint tgt_x = 0, tgt_y = 0, tgt_vx = 65536, tgt_vy = -32768;

    task automatic send_meas(logic [31:0] mx, logic [31:0] my);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {my, mx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        est_q.insert(est_q.size(), track_step(mx, my));
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(0, 30) : 0;
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        idle_input();
        while (est_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [kt2_pkg::CFG_IDX_W-1:0] idx,
                             logic [kt2_pkg::REG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            kt2_pkg::CFG_STEP_TIME:     dt_reg = val;
            kt2_pkg::CFG_PROCESS_NOISE: qn_reg = val;
            kt2_pkg::CFG_MEASURE_NOISE: rn_reg = val;
            kt2_pkg::CFG_INITIAL_COV:   pinit_reg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [kt2_pkg::REG_W-1:0] dt, logic [kt2_pkg::REG_W-1:0] qn,
                            logic [kt2_pkg::REG_W-1:0] rn);
        wait_drained();
        write_reg(kt2_pkg::CFG_STEP_TIME, dt);
        write_reg(kt2_pkg::CFG_PROCESS_NOISE, qn);
        write_reg(kt2_pkg::CFG_MEASURE_NOISE, rn);
    endtask

    // mostly a noisy moving target, some wild and some extreme values
    task automatic send_random();
        int sel;
        logic [31:0] mx, my;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            tgt_x += tgt_vx;
            tgt_y += tgt_vy;
            if ($urandom_range(0, 19) == 0) begin
                tgt_vx = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
                tgt_vy = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
            end
            mx = 32'(q_sat(tgt_x + longint'($urandom_range(0, 1 << 18)) - (1 << 17)));
            my = 32'(q_sat(tgt_y + longint'($urandom_range(0, 1 << 18)) - (1 << 17)));
            if (tgt_x > (1 << 28) || tgt_x < -(1 << 28)) tgt_x = 0;
            if (tgt_y > (1 << 28) || tgt_y < -(1 << 28)) tgt_y = 0;
        end else if (sel < 88) begin
            mx = $urandom;
            my = $urandom;
        end else begin
            mx = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            my = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom_range(0, 255);
        end
        send_meas(mx, my);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // first item loads a zero covariance; no noise keeps every step singular
    task automatic test_first_singular();
        write_reg(CFG_IDX_UNUSED_LO, REG_MAX);
        write_reg(kt2_pkg::CFG_INITIAL_COV, '0);
        set_regs('0, '0, '0);
        send_meas(32'h0001_0000, 32'hFFFF_0000);
        send_meas(32'h7FFF_FFFF, 32'h8000_0000);
        send_meas(32'h1234_5678, 32'h8765_4321);
        wait_drained();
        write_reg(kt2_pkg::CFG_INITIAL_COV, REG_MAX);
    endtask

    // field extremes under the default settings
    task automatic test_extremes();
        logic [31:0] vals [6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000};
        set_regs(kt2_pkg::RST_STEP_TIME, kt2_pkg::RST_PROCESS_NOISE,
                 kt2_pkg::RST_MEASURE_NOISE);
        write_reg(CFG_IDX_UNUSED_HI, '0);
        for (int i = 0; i < 6; i++)
            send_meas(vals[i], vals[5 - i]);
        for (int i = 0; i < 6; i++)
            send_meas(vals[i], vals[i]);
    endtask

    // receiver holds off while measurements keep coming
    task automatic test_backpressure();
        wait_drained();
        hold_len = 8000;
        hold_tog = ~hold_tog;
        gaps_on = 1'b0;
        for (int i = 0; i < 6; i++) send_random();
        gaps_on = 1'b1;
        wait_drained();
    endtask

    // random measurements across a set of register settings
    task automatic test_random_settings();
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_regs(kt2_pkg::RST_STEP_TIME, kt2_pkg::RST_PROCESS_NOISE,
                            kt2_pkg::RST_MEASURE_NOISE);
                1: set_regs('0, '0, 31'd65536);
                2: set_regs(REG_MAX, REG_MAX, REG_MAX);
                3: set_regs(31'd65536, 31'd655, 31'd65536);
                4: set_regs(31'd6554, '0, '0);
                5: set_regs(31'd65536, 31'd1, REG_MAX);
                default: set_regs(31'($urandom), 31'($urandom_range(0, 1 << 20)),
                                  31'($urandom_range(0, 1 << 24)));
            endcase
            gaps_on = (ph != 3);
            for (int i = 0; i < 210; i++) send_random();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_singular();
        test_extremes();
        test_backpressure();
        test_random_settings();
        wait_drained();
        repeat (2000) @(posedge i_clk);
        if (n_err == 0 && est_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
